@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the token bucket shaper RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tbs_pkg.sv @@
// Types and constants for the token bucket shaper.
// No dependencies; imported by token_bucket_shaper.
package tbs_pkg;

  // Event kinds on the input channel.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  // Register index select (paddr[2]) and reset value of the capacity register.
  localparam logic       REG_CAPACITY  = 1'b0;
  localparam logic [7:0] CAPACITY_RST  = 8'd10;

  typedef enum logic [2:0] {
    ST_TOKEN_ADDED   = 3'd0,
    ST_TOKEN_DROPPED = 3'd1,
    ST_PKT_QUEUED    = 3'd2,
    ST_PKT_TOO_LARGE = 3'd3,
    ST_PKT_QUEUE_FULL = 3'd4
  } status_t;

  // One waiting packet.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  need;
  } entry_t;

endpackage

@@ rtl/core/token_bucket_shaper.sv @@
// Token bucket traffic shaper: input register, single-pass event logic, result register.
// Depends on tbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

// The shaper takes one event per beat: a token tick or a packet arrival. busy is
// always low, so an event can be issued on every clock; each accepted beat yields
// exactly one result via the input and result registers, shown for one cycle with
// out_valid high. The receiver cannot stall results; none are ever held back or merged.
// Throughput is one event per cycle, set by the single pass from the input
// register through the bucket compare/add/subtract and the FIFO pointers into the
// result register. Waiting packets sit in a QUEUE_DEPTH-entry memory; the head
// entry and the entry behind it are kept in registers so that a release never
// waits on a memory read. The memory needs no clearing pass after reset: only
// written entries are ever released. bucket_capacity sits at byte address 0 of
// the APB port and should be changed only while no event is in flight.
module token_bucket_shaper #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Event channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [15:0]           in_packet_id,
  input  logic [7:0]            in_tokens_needed,
  // Result channel
  output logic                  out_valid,
  output tbs_pkg::status_t      out_status,
  output logic                  out_released,
  output logic [15:0]           out_released_id,
  output logic [7:0]            out_released_tokens,
  output logic [7:0]            out_bucket_level,
  output logic [4:0]            out_queue_count,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tbs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PTR_LAST) ? '0 : PW'(p + 1'b1);
    return r;
  endfunction

  // Configuration register.
  logic [7:0] cap_r;
  logic       cfg_wr;

  // Input register.
  logic        v1_r;
  logic        cmd1_r;
  entry_t      ent1_r;

  // Bucket and FIFO state.
  logic [7:0]    lvl_r, lvl_nxt;
  logic [PW-1:0] hd_ptr_r, hd_ptr_nxt;
  logic [PW-1:0] tl_ptr_r, tl_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  entry_t        head_r, head_nxt;

  // Look-ahead on the entry behind the head, with write bypass.
  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_data_r;
  entry_t        byp_data_r;
  logic          byp_r;
  logic [PW-1:0] rd_addr;
  logic          byp_hit;
  entry_t        behind_head;

  // Event decode.
  logic    push;
  logic    rel;
  status_t st;
  logic [7:0] lvl_tick;
  entry_t  rel_ent;

  // Result register.
  logic       out_valid_r;
  status_t    out_status_r;
  logic       out_released_r;
  entry_t     out_ent_r;
  logic [7:0] out_level_r;
  logic [4:0] out_count_r;

  // ---------------------------------------------------------------------------
  // APB register. Zero-wait, so pready is tied high; the write lands on the
  // access phase. Any byte address with paddr[2] low (0 to 3) decodes to the capacity register.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RST;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {24'd0, cap_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. Every event is taken; busy never rises.
  // ---------------------------------------------------------------------------
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd1_r      <= in_cmd;
      ent1_r.id   <= in_packet_id;
      ent1_r.need <= in_tokens_needed;
    end
  end

  // ---------------------------------------------------------------------------
  // Event logic. A tick first adds a token unless the bucket is at capacity,
  // then tests the head of the queue. An arrival is checked against the
  // capacity before the queue fill; it may only leave at once when the queue
  // was empty, in which case it is pushed and popped in the same cycle.
  // ---------------------------------------------------------------------------
  assign behind_head = byp_r ? byp_data_r : rd_data_r;

  always_comb begin
    push     = 1'b0;
    rel      = 1'b0;
    st       = ST_TOKEN_ADDED;
    lvl_tick = lvl_r;
    rel_ent  = head_r;
    lvl_nxt  = lvl_r;

    if (v1_r) begin
      if (cmd1_r == CMD_TICK) begin
        if (lvl_r >= cap_r) begin
          st = ST_TOKEN_DROPPED;
        end else begin
          lvl_tick = 8'(lvl_r + 8'd1);
        end
        lvl_nxt = lvl_tick;
        if ((cnt_r != '0) && (lvl_tick >= head_r.need)) begin
          rel     = 1'b1;
          rel_ent = head_r;
          lvl_nxt = 8'(lvl_tick - head_r.need);
        end
      end else if (ent1_r.need > cap_r) begin
        st = ST_PKT_TOO_LARGE;
      end else if (cnt_r == CNT_FULL) begin
        st = ST_PKT_QUEUE_FULL;
      end else begin
        st   = ST_PKT_QUEUED;
        push = 1'b1;
        if ((cnt_r == '0) && (lvl_r >= ent1_r.need)) begin
          rel     = 1'b1;
          rel_ent = ent1_r;
          lvl_nxt = 8'(lvl_r - ent1_r.need);
        end
      end
    end
  end

  // Pointers, count and the registered head entry.
  always_comb begin
    tl_ptr_nxt = push ? next_slot(tl_ptr_r) : tl_ptr_r;
    hd_ptr_nxt = rel ? next_slot(hd_ptr_r) : hd_ptr_r;

    cnt_nxt = cnt_r;
    if (push && !rel) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (rel && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end

    head_nxt = head_r;
    if (push && (cnt_r == '0)) begin
      head_nxt = ent1_r;
    end else if (rel) begin
      head_nxt = behind_head;
    end

    // Fetch the slot behind the next head; a same-cycle push there is bypassed.
    rd_addr = next_slot(hd_ptr_nxt);
    byp_hit = push && (tl_ptr_r == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r    <= '0;
      hd_ptr_r <= '0;
      tl_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      lvl_r    <= lvl_nxt;
      hd_ptr_r <= hd_ptr_nxt;
      tl_ptr_r <= tl_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    byp_r      <= byp_hit;
    byp_data_r <= ent1_r;
  end

  // Packet memory: one write port at the tail, one registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tl_ptr_r] <= ent1_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Result register. Released fields read zero when nothing left the queue.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      out_released_r <= 1'b0;
    end else begin
      out_valid_r    <= v1_r;
      out_released_r <= rel;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= st;
    out_ent_r    <= rel ? rel_ent : '0;
    out_level_r  <= lvl_nxt;
    out_count_r  <= 5'(cnt_nxt);
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_released        = out_released_r;
  assign out_released_id     = out_ent_r.id;
  assign out_released_tokens = out_ent_r.need;
  assign out_bucket_level    = out_level_r;
  assign out_queue_count     = out_count_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `AST_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_FULL, "queue count above depth")
  `AST_IMPL(a_empty_ptrs, clk, rst_n, cnt_r == '0, hd_ptr_r == tl_ptr_r,
            "empty queue with unequal pointers")
  `AST_NEXT(a_one_result, clk, rst_n, v1_r, out_valid_r, "accepted event lost its result")
  `AST_IMPL(a_rel_status, clk, rst_n, out_valid_r && out_released_r,
            out_status_r != ST_PKT_TOO_LARGE && out_status_r != ST_PKT_QUEUE_FULL,
            "release on a dropped arrival")
  `AST_IMPL(a_rel_empty, clk, rst_n,
            out_valid_r && out_released_r && out_status_r == ST_PKT_QUEUED,
            out_count_r == 5'd0, "immediate release left the queue non-empty")

endmodule
